@@ sv/pbr_pkg.sv @@
package pbr_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_DEGREE   = 5;
    localparam int MAX_HALVINGS = FRAC_BITS + 1;

    localparam int XW     = 18;
    localparam int PRECW  = 18;
    localparam int COEFW  = 32;
    localparam int ACCW   = 48;
    localparam int STEPW  = 5;
    localparam int DEGW   = 3;
    localparam int IDXW   = 3;
    localparam int CFG_AW = 3;
    localparam int SPLIT  = 24;
    localparam int PHW    = ACCW - SPLIT + XW;
    localparam int PLW    = SPLIT + 1 + XW;
    localparam int SUMW   = ACCW + 2;

    localparam logic signed [XW-1:0] ONE_Q = XW'(1) << FRAC_BITS;

    localparam logic [CFG_AW-1:0] REG_DEGREE = 3'd0;
    localparam logic [CFG_AW-1:0] REG_COEF0  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_COEF5  = 3'd6;

    typedef enum logic [1:0] {
        ST_CONVERGED = 2'd0,
        ST_EXACT     = 2'd1,
        ST_NO_CHANGE = 2'd2,
        ST_LEAD_ZERO = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        XSEL_LO  = 2'd0,
        XSEL_HI  = 2'd1,
        XSEL_MID = 2'd2
    } xsel_t;

    typedef struct packed {
        logic    start;
        logic    load;
        xsel_t   xsel;
        logic    mul;
        logic    add;
        logic    cap_lo;
        logic    bisect;
        logic    emit;
        status_t status;
    } pbr_cmd_t;

    typedef struct packed {
        logic lead_zero;
        logic horner_last;
        logic acc_zero;
        logic no_change;
        logic loop_cont;
        logic out_busy;
    } pbr_stat_t;

endpackage

@@ sv/polynomial_bisection_root_unit.sv @@
// Channel   Dir  Ports                         Contents
// s_ (in)   in   s_tvalid s_tready s_tdata     precision
// m_ (out)  out  m_tvalid m_tready m_tdata     root, status, halvings
// cfg       in   cfg_wr_en cfg_addr cfg_wdata  degree, coef_deg0..coef_deg5
//
// One request at a time; each Horner step is one multiply state and one
// add state through the shared datapath (S_MUL, then S_ADD).
// Reset is synchronous, active low; coefficients return to f(x) = x.
// The result register holds one finished result while the next request is taken.
module polynomial_bisection_root_unit
    import pbr_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [COEFW-1:0]    cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,  // [17:0] precision
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata   // [17:0] root, [19:18] status, [24:20] halvings
);

    pbr_cmd_t              cmd;
    pbr_stat_t             stat;
    logic signed [XW-1:0]  root;
    status_t               status;
    logic [STEPW-1:0]      halvings;

    pbr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pbr_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_precision (s_tdata[PRECW-1:0]),
        .cmd         (cmd),
        .stat        (stat),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_root      (root),
        .m_status    (status),
        .m_halvings  (halvings)
    );

    assign m_tdata = {7'd0, halvings, status, root};

endmodule

@@ sv/pbr_datapath.sv @@
module pbr_datapath
    import pbr_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_AW-1:0]       cfg_addr,
    input  logic [COEFW-1:0]        cfg_wdata,
    input  logic [PRECW-1:0]        s_precision,
    input  pbr_cmd_t                cmd,
    output pbr_stat_t               stat,
    input  logic                    m_tready,
    output logic                    m_tvalid,
    output logic signed [XW-1:0]    m_root,
    output status_t                 m_status,
    output logic [STEPW-1:0]        m_halvings
);

    localparam logic signed [SUMW-1:0] ACC_MAX = (SUMW'(1) <<< (ACCW - 1)) - SUMW'(1);
    localparam logic signed [SUMW-1:0] ACC_MIN = -(SUMW'(1) <<< (ACCW - 1));

    logic [DEGW-1:0]           degree_reg;
    logic signed [COEFW-1:0]   coef_reg [0:MAX_DEGREE];

    logic [PRECW-1:0]          prec_reg;
    logic signed [XW-1:0]      lo_reg;
    logic signed [XW-1:0]      hi_reg;
    logic signed [XW-1:0]      x_reg;
    logic                      slo_neg_reg;
    logic                      slo_zero_reg;
    logic signed [ACCW-1:0]    acc_reg;
    logic [IDXW-1:0]           idx_reg;
    logic signed [PHW-1:0]     ph_reg;
    logic signed [PLW-1:0]     pl_reg;
    logic [STEPW-1:0]          step_reg;

    logic                      m_valid_reg;
    logic signed [XW-1:0]      root_reg;
    status_t                   status_reg;
    logic [STEPW-1:0]          halv_reg;

    logic [IDXW-1:0]           eff_deg;
    logic [IDXW-1:0]           rd_addr;
    logic signed [COEFW-1:0]   coef_rd;
    logic signed [XW:0]        bound_sum;
    logic signed [XW:0]        width;
    logic signed [XW-1:0]      mid;
    logic signed [XW-1:0]      x_next;
    logic signed [SPLIT-1:0]   acc_hi;
    logic signed [SPLIT:0]     acc_lo;
    logic signed [SUMW-1:0]    horner_sum;
    logic signed [ACCW-1:0]    acc_sat;
    logic                      acc_neg;
    logic                      acc_zero;

    always_comb begin
        if (degree_reg == '0) begin
            eff_deg = IDXW'(1);
        end else if (degree_reg > DEGW'(MAX_DEGREE)) begin
            eff_deg = IDXW'(MAX_DEGREE);
        end else begin
            eff_deg = degree_reg;
        end
    end

    assign rd_addr   = cmd.add ? (idx_reg - IDXW'(1)) : eff_deg;
    assign coef_rd   = coef_reg[rd_addr];
    assign bound_sum = {lo_reg[XW-1], lo_reg} + {hi_reg[XW-1], hi_reg};
    assign mid       = bound_sum[XW:1];
    assign width     = {hi_reg[XW-1], hi_reg} - {lo_reg[XW-1], lo_reg};

    always_comb begin
        case (cmd.xsel)
            XSEL_LO:  x_next = -ONE_Q;
            XSEL_HI:  x_next = ONE_Q;
            XSEL_MID: x_next = mid;
            default:  x_next = mid;
        endcase
    end

    assign acc_hi = acc_reg[ACCW-1:SPLIT];
    assign acc_lo = $signed({1'b0, acc_reg[SPLIT-1:0]});

    assign horner_sum = (SUMW'(ph_reg) <<< (SPLIT - FRAC_BITS))
                      + SUMW'(pl_reg >>> FRAC_BITS)
                      + SUMW'(coef_rd);

    always_comb begin
        if (horner_sum > ACC_MAX) begin
            acc_sat = ACC_MAX[ACCW-1:0];
        end else if (horner_sum < ACC_MIN) begin
            acc_sat = ACC_MIN[ACCW-1:0];
        end else begin
            acc_sat = horner_sum[ACCW-1:0];
        end
    end

    assign acc_neg  = acc_reg[ACCW-1];
    assign acc_zero = (acc_reg == '0);

    assign stat.lead_zero   = (coef_rd == '0);
    assign stat.horner_last = (idx_reg == IDXW'(1));
    assign stat.acc_zero    = acc_zero;
    assign stat.no_change   = !slo_zero_reg && !acc_zero && (acc_neg == slo_neg_reg);
    assign stat.loop_cont   = (width > $signed({1'b0, prec_reg}))
                           && (step_reg < STEPW'(MAX_HALVINGS));
    assign stat.out_busy    = m_valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= DEGW'(1);
            for (int k = 0; k <= MAX_DEGREE; k++) begin
                coef_reg[k] <= (k == 1) ? COEFW'(ONE_Q) : '0;
            end
        end else if (cfg_wr_en) begin
            if (cfg_addr == REG_DEGREE) begin
                degree_reg <= cfg_wdata[DEGW-1:0];
            end else if (cfg_addr >= REG_COEF0 && cfg_addr <= REG_COEF5) begin
                coef_reg[cfg_addr - REG_COEF0] <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            prec_reg <= (s_precision == '0) ? PRECW'(1) : s_precision;
            lo_reg   <= -ONE_Q;
            hi_reg   <= ONE_Q;
        end
        if (cmd.load) begin
            x_reg   <= x_next;
            acc_reg <= ACCW'(coef_rd);
            idx_reg <= eff_deg;
        end
        if (cmd.mul) begin
            ph_reg <= acc_hi * x_reg;
            pl_reg <= acc_lo * x_reg;
        end
        if (cmd.add) begin
            acc_reg <= acc_sat;
            idx_reg <= idx_reg - IDXW'(1);
        end
        if (cmd.cap_lo) begin
            slo_neg_reg  <= acc_neg;
            slo_zero_reg <= acc_zero;
        end
        if (cmd.bisect) begin
            if (!slo_zero_reg && (acc_neg != slo_neg_reg)) begin
                hi_reg <= x_reg;
            end else begin
                lo_reg       <= x_reg;
                slo_neg_reg  <= acc_neg;
                slo_zero_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else if (cmd.start) begin
            step_reg <= '0;
        end else if (cmd.bisect) begin
            step_reg <= step_reg + STEPW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            status_reg <= cmd.status;
            halv_reg   <= step_reg;
            if (cmd.status == ST_NO_CHANGE || cmd.status == ST_LEAD_ZERO) begin
                root_reg <= '0;
            end else begin
                root_reg <= mid;
            end
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_root     = root_reg;
    assign m_status   = status_reg;
    assign m_halvings = halv_reg;

    a_step_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= STEPW'(MAX_HALVINGS))
        else $error("halving count past cap");

    a_bisect_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.bisect |=> (width < $past(width)))
        else $error("bisection did not narrow the interval");

    a_early_no_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && (cmd.status == ST_NO_CHANGE || cmd.status == ST_LEAD_ZERO))
            |-> (step_reg == '0))
        else $error("halvings counted on an early exit");

endmodule

@@ sv/pbr_ctrl.sv @@
module pbr_ctrl
    import pbr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  pbr_stat_t stat,
    output pbr_cmd_t  cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_CHECK    = 9'b000000010,
        S_MUL      = 9'b000000100,
        S_ADD      = 9'b000001000,
        S_SIGN_LO  = 9'b000010000,
        S_SIGN_HI  = 9'b000100000,
        S_TEST     = 9'b001000000,
        S_SIGN_MID = 9'b010000000,
        S_DONE     = 9'b100000000
    } state_t;

    state_t  state_reg, state_next;
    state_t  ret_reg, ret_next;
    status_t status_reg, status_next;

    always_comb begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (stat.lead_zero) begin
                    status_next = ST_LEAD_ZERO;
                    state_next  = S_DONE;
                end else begin
                    cmd.load   = 1'b1;
                    cmd.xsel   = XSEL_LO;
                    ret_next   = S_SIGN_LO;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_ADD;
            end
            S_ADD: begin
                cmd.add    = 1'b1;
                state_next = stat.horner_last ? ret_reg : S_MUL;
            end
            S_SIGN_LO: begin
                cmd.cap_lo = 1'b1;
                cmd.load   = 1'b1;
                cmd.xsel   = XSEL_HI;
                ret_next   = S_SIGN_HI;
                state_next = S_MUL;
            end
            S_SIGN_HI: begin
                if (stat.no_change) begin
                    status_next = ST_NO_CHANGE;
                    state_next  = S_DONE;
                end else begin
                    state_next = S_TEST;
                end
            end
            S_TEST: begin
                if (stat.loop_cont) begin
                    cmd.load   = 1'b1;
                    cmd.xsel   = XSEL_MID;
                    ret_next   = S_SIGN_MID;
                    state_next = S_MUL;
                end else begin
                    status_next = ST_CONVERGED;
                    state_next  = S_DONE;
                end
            end
            S_SIGN_MID: begin
                if (stat.acc_zero) begin
                    status_next = ST_EXACT;
                    state_next  = S_DONE;
                end else begin
                    cmd.bisect = 1'b1;
                    state_next = S_TEST;
                end
            end
            S_DONE: begin
                if (!stat.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            ret_reg    <= S_SIGN_LO;
            status_reg <= ST_CONVERGED;
        end else begin
            state_reg  <= state_next;
            ret_reg    <= ret_next;
            status_reg <= status_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !stat.out_busy)
        else $error("result written over a pending transfer");

    a_horner_return: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ADD && stat.horner_last) |=> (state_reg == $past(ret_reg)))
        else $error("evaluation did not return to its caller");

    a_accept_check: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_CHECK))
        else $error("accepted transfer not checked");

endmodule
